[design/aetc_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aetc_pkg
// Shared types and constants of the admittance energy tank controller.
// ---------------------------------------------------------------------------
package aetc_pkg;

  localparam int NumAxes        = 6;
  localparam int AxisW          = 3;
  localparam int FracBits       = 16;
  localparam int ForceDeadband  = 196608;
  localparam int TorqueDeadband = 3277;
  localparam int CfgIdxW        = 3;
  localparam int CfgDataW       = 31;
  localparam int ProdW          = 74;

  // register indexes of the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    CFG_DAMP_LIN  = 3'd0,
    CFG_DAMP_ROT  = 3'd1,
    CFG_GAIN_LIN  = 3'd2,
    CFG_GAIN_ROT  = 3'd3,
    CFG_DRAIN     = 3'd4,
    CFG_THRESHOLD = 3'd5,
    CFG_EMAX      = 3'd6,
    CFG_SPAN      = 3'd7
  } cfg_idx_e;

  // datapath operations, each one multiply and one accumulate step
  typedef enum logic [2:0] {
    OP_PIN, OP_POUT, OP_DAMP, OP_GAIN, OP_DRAIN, OP_RATIO, OP_HELD
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_FIN
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [AxisW-1:0] axis;
    logic             load_in;
    logic             mul_en;
    logic             acc_en;
    logic             load_out;
  } cmd_t;

endpackage

[design/aetc_ctrl.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aetc_ctrl
// Sequencer: walks the per-axis operations, the tank update and the held
// force update, and runs the input and output handshakes.
// ---------------------------------------------------------------------------
module aetc_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output aetc_pkg::cmd_t  cmd_o
);

  aetc_pkg::state_e state_q, state_d;
  aetc_pkg::op_e    op_q, op_d;
  logic [aetc_pkg::AxisW-1:0] axis_q, axis_d;
  logic out_valid_q, out_valid_d;
  localparam logic [aetc_pkg::AxisW-1:0] LastAxis = aetc_pkg::AxisW'(aetc_pkg::NumAxes - 1);

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aetc_pkg::ST_IDLE;
      op_q        <= aetc_pkg::OP_PIN;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    axis_d         = axis_q;
    out_valid_d    = out_valid_q && out_stall_i;
    cmd_o.op       = op_q;
    cmd_o.axis     = axis_q;
    cmd_o.load_in  = 1'b0;
    cmd_o.mul_en   = 1'b0;
    cmd_o.acc_en   = 1'b0;
    cmd_o.load_out = 1'b0;
    unique case (state_q)
      aetc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          op_d          = aetc_pkg::OP_PIN;
          axis_d        = '0;
          state_d       = aetc_pkg::ST_MUL;
        end
      end
      aetc_pkg::ST_MUL: begin
        cmd_o.mul_en = 1'b1;
        state_d      = aetc_pkg::ST_ACC;
      end
      aetc_pkg::ST_ACC: begin
        cmd_o.acc_en = 1'b1;
        state_d      = aetc_pkg::ST_MUL;
        unique case (op_q)
          aetc_pkg::OP_PIN:  op_d = aetc_pkg::OP_POUT;
          aetc_pkg::OP_POUT: op_d = aetc_pkg::OP_DAMP;
          aetc_pkg::OP_DAMP: op_d = aetc_pkg::OP_GAIN;
          aetc_pkg::OP_GAIN: begin
            if (axis_q == LastAxis) begin
              op_d = aetc_pkg::OP_DRAIN;
            end else begin
              op_d   = aetc_pkg::OP_PIN;
              axis_d = axis_q + 1'b1;
            end
          end
          aetc_pkg::OP_DRAIN: op_d = aetc_pkg::OP_RATIO;
          aetc_pkg::OP_RATIO: begin
            op_d   = aetc_pkg::OP_HELD;
            axis_d = '0;
          end
          aetc_pkg::OP_HELD: begin
            if (axis_q == LastAxis) begin
              state_d = aetc_pkg::ST_FIN;
            end else begin
              axis_d = axis_q + 1'b1;
            end
          end
          default: state_d = aetc_pkg::ST_IDLE;
        endcase
      end
      aetc_pkg::ST_FIN: begin
        // wait for the output register to free up
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = aetc_pkg::ST_IDLE;
        end
      end
      default: state_d = aetc_pkg::ST_IDLE;
    endcase
  end

  assign in_stall_o  = (state_q != aetc_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

[design/aetc_datapath.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// aetc_datapath
// Configuration registers, controller state, one shared registered
// multiplier and the accumulate and saturation logic.
// ---------------------------------------------------------------------------
module aetc_datapath (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  aetc_pkg::cmd_t                       cmd_i,
  input  logic                                 cfg_we_i,
  input  logic [aetc_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  logic [aetc_pkg::CfgDataW-1:0]        cfg_data_i,
  input  logic signed [31:0]                   force_x_i,
  input  logic signed [31:0]                   force_y_i,
  input  logic signed [31:0]                   force_z_i,
  input  logic signed [31:0]                   torque_x_i,
  input  logic signed [31:0]                   torque_y_i,
  input  logic signed [31:0]                   torque_z_i,
  output logic signed [31:0]                   vel_x_o,
  output logic signed [31:0]                   vel_y_o,
  output logic signed [31:0]                   vel_z_o,
  output logic signed [31:0]                   ang_x_o,
  output logic signed [31:0]                   ang_y_o,
  output logic signed [31:0]                   ang_z_o,
  output logic [16:0]                          ratio_out_o,
  output logic [30:0]                          energy_out_o
);

  localparam logic [16:0] RatioOne = 17'd65536;
  localparam logic signed [63:0] NetMax = 64'sd549755813887;
  localparam logic signed [63:0] NetMin = -64'sd549755813888;
  localparam logic signed [63:0] VelMax = 64'sd2147483647;
  localparam logic signed [63:0] VelMin = -64'sd2147483648;

  // configuration
  logic [23:0] damp_lin_q, damp_rot_q, gain_lin_q, gain_rot_q, drain_q, span_q;
  logic [30:0] thr_q, emax_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      damp_lin_q <= 24'd1310720;
      damp_rot_q <= 24'd655360;
      gain_lin_q <= 24'd11185;
      gain_rot_q <= 24'd22370;
      drain_q    <= 24'd16384;
      thr_q      <= 31'd655360;
      emax_q     <= 31'd3276800;
      span_q     <= 24'd419430;
    end else if (cfg_we_i) begin
      unique case (aetc_pkg::cfg_idx_e'(cfg_idx_i))
        aetc_pkg::CFG_DAMP_LIN:  damp_lin_q <= cfg_data_i[23:0];
        aetc_pkg::CFG_DAMP_ROT:  damp_rot_q <= cfg_data_i[23:0];
        aetc_pkg::CFG_GAIN_LIN:  gain_lin_q <= cfg_data_i[23:0];
        aetc_pkg::CFG_GAIN_ROT:  gain_rot_q <= cfg_data_i[23:0];
        aetc_pkg::CFG_DRAIN:     drain_q    <= cfg_data_i[23:0];
        aetc_pkg::CFG_THRESHOLD: thr_q      <= cfg_data_i;
        aetc_pkg::CFG_EMAX:      emax_q     <= cfg_data_i;
        aetc_pkg::CFG_SPAN:      span_q     <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // working registers
  logic signed [31:0] f_q    [aetc_pkg::NumAxes];
  logic signed [31:0] v_q    [aetc_pkg::NumAxes];
  logic signed [31:0] held_q [aetc_pkg::NumAxes];
  logic [30:0]        energy_q;
  logic [16:0]        ratio_q;
  logic signed [63:0] acc_q;
  logic signed [39:0] net_q;
  logic signed [aetc_pkg::ProdW-1:0] prod_q;

  // deadband on capture
  logic signed [31:0] raw    [aetc_pkg::NumAxes];
  logic signed [31:0] f_in   [aetc_pkg::NumAxes];
  always_comb begin
    raw[0] = force_x_i;  raw[1] = force_y_i;  raw[2] = force_z_i;
    raw[3] = torque_x_i; raw[4] = torque_y_i; raw[5] = torque_z_i;
    for (int i = 0; i < aetc_pkg::NumAxes; i++) begin
      logic signed [32:0] x, db;
      x  = {raw[i][31], raw[i]};
      db = (i < 3) ? 33'(aetc_pkg::ForceDeadband) : 33'(aetc_pkg::TorqueDeadband);
      f_in[i] = (x < db && x > -db) ? 32'sd0 : raw[i];
    end
  end

  // operand select
  logic               lin;
  logic signed [31:0] fa, va, ha;
  logic signed [40:0] op_a;
  logic signed [32:0] op_b;
  logic [31:0]        e_diff;
  always_comb begin
    lin    = (cmd_i.axis < 3'd3);
    fa     = f_q[cmd_i.axis];
    va     = v_q[cmd_i.axis];
    ha     = held_q[cmd_i.axis];
    e_diff = {1'b0, energy_q} - {1'b0, thr_q};
    op_a   = '0;
    op_b   = '0;
    case (cmd_i.op)
      aetc_pkg::OP_PIN: begin
        op_a = {{9{va[31]}}, va};
        op_b = {fa[31], fa};
      end
      aetc_pkg::OP_POUT: begin
        op_a = {{9{va[31]}}, va};
        op_b = {ha[31], ha};
      end
      aetc_pkg::OP_DAMP: begin
        op_a = {17'd0, (lin ? damp_lin_q : damp_rot_q)};
        op_b = {va[31], va};
      end
      aetc_pkg::OP_GAIN: begin
        op_a = {net_q[39], net_q};
        op_b = {9'd0, (lin ? gain_lin_q : gain_rot_q)};
      end
      aetc_pkg::OP_DRAIN: begin
        op_a = {24'd0, RatioOne - ratio_q};
        op_b = {9'd0, drain_q};
      end
      aetc_pkg::OP_RATIO: begin
        op_a = {{9{e_diff[31]}}, e_diff};
        op_b = {9'd0, span_q};
      end
      aetc_pkg::OP_HELD: begin
        op_a = {24'd0, ratio_q};
        op_b = {fa[31], fa};
      end
      default: ;
    endcase
  end

  // scaled product
  logic signed [aetc_pkg::ProdW-1:0] prod_sh;
  logic signed [63:0] sh;
  logic signed [63:0] net_full, v_sum, e_sum;
  always_comb begin
    case (cmd_i.op) inside
      aetc_pkg::OP_GAIN:                    prod_sh = prod_q >>> 24;
      aetc_pkg::OP_DRAIN, aetc_pkg::OP_HELD: prod_sh = prod_q >>> 16;
      aetc_pkg::OP_RATIO:                   prod_sh = prod_q >>> (aetc_pkg::FracBits + 8);
      default:                              prod_sh = prod_q >>> aetc_pkg::FracBits;
    endcase
    sh       = prod_sh[63:0];
    net_full = {{32{fa[31]}}, fa} - sh;
    v_sum    = {{32{va[31]}}, va} + sh;
    e_sum    = acc_q - sh;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q <= '0;
      ratio_q  <= '0;
      for (int i = 0; i < aetc_pkg::NumAxes; i++) begin
        v_q[i]    <= '0;
        held_q[i] <= '0;
      end
    end else if (cmd_i.acc_en) begin
      case (cmd_i.op)
        aetc_pkg::OP_GAIN: begin
          if (v_sum > VelMax)      v_q[cmd_i.axis] <= 32'sh7fffffff;
          else if (v_sum < VelMin) v_q[cmd_i.axis] <= 32'sh80000000;
          else                     v_q[cmd_i.axis] <= v_sum[31:0];
        end
        aetc_pkg::OP_DRAIN: begin
          if (e_sum < 0)                            energy_q <= '0;
          else if (e_sum > $signed({33'd0, emax_q})) energy_q <= emax_q;
          else                                      energy_q <= e_sum[30:0];
        end
        aetc_pkg::OP_RATIO: begin
          if (energy_q <= thr_q)                    ratio_q <= '0;
          else if (sh > $signed({47'd0, RatioOne})) ratio_q <= RatioOne;
          else                                      ratio_q <= sh[16:0];
        end
        aetc_pkg::OP_HELD: held_q[cmd_i.axis] <= sh[31:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      for (int i = 0; i < aetc_pkg::NumAxes; i++) f_q[i] <= f_in[i];
      acc_q <= {33'd0, energy_q};
    end
    if (cmd_i.mul_en) prod_q <= op_a * op_b;
    if (cmd_i.acc_en) begin
      case (cmd_i.op)
        aetc_pkg::OP_PIN:  acc_q <= acc_q + sh;
        aetc_pkg::OP_POUT: acc_q <= acc_q - sh;
        aetc_pkg::OP_DAMP: begin
          if (net_full > NetMax)      net_q <= NetMax[39:0];
          else if (net_full < NetMin) net_q <= NetMin[39:0];
          else                        net_q <= net_full[39:0];
        end
        default: ;
      endcase
    end
    if (cmd_i.load_out) begin
      vel_x_o      <= v_q[0];
      vel_y_o      <= v_q[1];
      vel_z_o      <= v_q[2];
      ang_x_o      <= v_q[3];
      ang_y_o      <= v_q[4];
      ang_z_o      <= v_q[5];
      ratio_out_o  <= ratio_q;
      energy_out_o <= energy_q;
    end
  end

endmodule

[design/admittance_energy_tank_controller.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// admittance_energy_tank_controller
// Six-axis admittance controller with a passivity energy tank.
// ---------------------------------------------------------------------------
// channel  direction  handshake               payload
// in       input      in_valid_i/in_stall_o   force_x..z, torque_x..z
// out      output     out_valid_o/out_stall_i vel_x..z, ang_x..z, ratio, energy
// cfg      input      cfg_we_i                cfg_idx_i, cfg_data_i
//
// Each sample runs 32 operations on the single shared multiplier, each a
// multiply and an accumulate step, and then loads the output register
// once it is free; the sequencer then returns to idle for the next transfer.
// Reset restores register defaults and clears velocity, held force, tank
// and ratio. A new sample is taken once the previous one has reached the
// output register; a result may wait there under out_stall_i meanwhile.
module admittance_energy_tank_controller (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [aetc_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [aetc_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [31:0]            force_x_i,
  input  logic signed [31:0]            force_y_i,
  input  logic signed [31:0]            force_z_i,
  input  logic signed [31:0]            torque_x_i,
  input  logic signed [31:0]            torque_y_i,
  input  logic signed [31:0]            torque_z_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic signed [31:0]            vel_x_o,
  output logic signed [31:0]            vel_y_o,
  output logic signed [31:0]            vel_z_o,
  output logic signed [31:0]            ang_x_o,
  output logic signed [31:0]            ang_y_o,
  output logic signed [31:0]            ang_z_o,
  output logic [16:0]                   ratio_out_o,
  output logic [30:0]                   energy_out_o
);

  aetc_pkg::cmd_t cmd;

  // sequencer
  aetc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // arithmetic and state
  aetc_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .force_x_i    (force_x_i),
    .force_y_i    (force_y_i),
    .force_z_i    (force_z_i),
    .torque_x_i   (torque_x_i),
    .torque_y_i   (torque_y_i),
    .torque_z_i   (torque_z_i),
    .vel_x_o      (vel_x_o),
    .vel_y_o      (vel_y_o),
    .vel_z_o      (vel_z_o),
    .ang_x_o      (ang_x_o),
    .ang_y_o      (ang_y_o),
    .ang_z_o      (ang_z_o),
    .ratio_out_o  (ratio_out_o),
    .energy_out_o (energy_out_o)
  );

endmodule

[tb/sv/tb_admittance_energy_tank_controller.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_admittance_energy_tank_controller
// Drives wrench samples through the controller and compares each result
// with a bit-accurate software predictor of the tank and velocity update.
// ---------------------------------------------------------------------------
module tb_admittance_energy_tank_controller;

  typedef struct packed {
    logic signed [31:0] fx, fy, fz, tx, ty, tz;
  } wrench_t;

  typedef struct packed {
    logic signed [31:0] vx, vy, vz, ax, ay, az;
    logic [16:0]        ratio;
    logic [30:0]        energy;
  } twist_t;

  localparam int WatchdogLimit = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  aetc_pkg::cfg_idx_e cfg_idx_i = aetc_pkg::CFG_DAMP_LIN;
  logic [aetc_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [31:0] force_x_i = '0, force_y_i = '0, force_z_i = '0;
  logic signed [31:0] torque_x_i = '0, torque_y_i = '0, torque_z_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [31:0] vel_x_o, vel_y_o, vel_z_o, ang_x_o, ang_y_o, ang_z_o;
  logic [16:0] ratio_out_o;
  logic [30:0] energy_out_o;

  admittance_energy_tank_controller dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // predictor state and register copy
  longint unsigned reg_val [8];
  longint vel_st [6];
  longint held_st [6];
  longint tank_e, tank_r;

  wrench_t pending_q [$];
  twist_t  twist_q [$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic in_fire = 1'b0;

  function automatic longint fl_shr(longint x, int s);
    return x >>> s;
  endfunction

  function automatic longint clampl(longint x, longint lo, longint hi);
    return x < lo ? lo : (x > hi ? hi : x);
  endfunction

  // one controller step, returns the predicted twist and updates state
  function automatic twist_t predict_twist(wrench_t w);
    longint f [6];
    longint dv [6];
    longint raw [6];
    longint pin, pout, drain, e, d, g, net, mag, db, r;
    longint lim40;
    twist_t t;
    lim40 = 64'sd1 <<< 39;
    raw[0] = w.fx; raw[1] = w.fy; raw[2] = w.fz;
    raw[3] = w.tx; raw[4] = w.ty; raw[5] = w.tz;
    pin = 0;
    pout = 0;
    for (int i = 0; i < 6; i++) begin
      mag = raw[i] < 0 ? -raw[i] : raw[i];
      db = i < 3 ? aetc_pkg::ForceDeadband : aetc_pkg::TorqueDeadband;
      f[i] = mag < db ? 0 : raw[i];
    end
    for (int i = 0; i < 6; i++) begin
      d = longint'(i < 3 ? reg_val[aetc_pkg::CFG_DAMP_LIN] : reg_val[aetc_pkg::CFG_DAMP_ROT]);
      g = longint'(i < 3 ? reg_val[aetc_pkg::CFG_GAIN_LIN] : reg_val[aetc_pkg::CFG_GAIN_ROT]);
      net = f[i] - fl_shr(d * vel_st[i], aetc_pkg::FracBits);
      net = clampl(net, -lim40, lim40 - 1);
      dv[i] = fl_shr(net * g, 24);
      pin += fl_shr(vel_st[i] * f[i], aetc_pkg::FracBits);
      pout += fl_shr(vel_st[i] * held_st[i], aetc_pkg::FracBits);
    end
    drain = ((65536 - tank_r) * longint'(reg_val[aetc_pkg::CFG_DRAIN])) >>> 16;
    e = tank_e + pin - pout - drain;
    tank_e = clampl(e, 0, longint'(reg_val[aetc_pkg::CFG_EMAX]));
    if (tank_e > longint'(reg_val[aetc_pkg::CFG_THRESHOLD])) begin
      r = ((tank_e - longint'(reg_val[aetc_pkg::CFG_THRESHOLD])) *
           longint'(reg_val[aetc_pkg::CFG_SPAN])) >>> (aetc_pkg::FracBits + 8);
      tank_r = r > 65536 ? 65536 : r;
    end else begin
      tank_r = 0;
    end
    for (int i = 0; i < 6; i++) begin
      held_st[i] = fl_shr(tank_r * f[i], 16);
      vel_st[i] = clampl(vel_st[i] + dv[i], -64'sd2147483648, 64'sd2147483647);
    end
    t.vx = vel_st[0][31:0]; t.vy = vel_st[1][31:0]; t.vz = vel_st[2][31:0];
    t.ax = vel_st[3][31:0]; t.ay = vel_st[4][31:0]; t.az = vel_st[5][31:0];
    t.ratio = tank_r[16:0];
    t.energy = tank_e[30:0];
    return t;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  // driver: presents queued samples, prediction made at transfer
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_fire) begin
        twist_q.push_back(predict_twist(pending_q.pop_front()));
      end
      if ((!in_valid_i || in_fire) && pending_q.size() > 0 &&
          $urandom_range(99) >= send_idle_pct) begin
        force_x_i  <= pending_q[0].fx;
        force_y_i  <= pending_q[0].fy;
        force_z_i  <= pending_q[0].fz;
        torque_x_i <= pending_q[0].tx;
        torque_y_i <= pending_q[0].ty;
        torque_z_i <= pending_q[0].tz;
        in_valid_i <= 1'b1;
      end else if (in_fire) begin
        in_valid_i <= 1'b0;
      end
      out_stall_i <= $urandom_range(99) < recv_stall_pct;
    end
  end

  // transfer sampling at the rising edge; driver pops at the next fall
  // monitor and watchdog
  int idle_cycles = 0;
  always @(posedge clk_i) begin
    twist_t want;
    if (rst_ni) begin
      in_fire <= in_valid_i && !in_stall_o;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (out_valid_o && !out_stall_i) begin
        if (twist_q.size() == 0) begin
          report_mismatch("unexpected result", 0, 0);
        end else begin
          want = twist_q.pop_front();
          if (vel_x_o !== want.vx) report_mismatch("vel_x", vel_x_o, want.vx);
          if (vel_y_o !== want.vy) report_mismatch("vel_y", vel_y_o, want.vy);
          if (vel_z_o !== want.vz) report_mismatch("vel_z", vel_z_o, want.vz);
          if (ang_x_o !== want.ax) report_mismatch("ang_x", ang_x_o, want.ax);
          if (ang_y_o !== want.ay) report_mismatch("ang_y", ang_y_o, want.ay);
          if (ang_z_o !== want.az) report_mismatch("ang_z", ang_z_o, want.az);
          if (ratio_out_o !== want.ratio)
            report_mismatch("ratio_out", ratio_out_o, want.ratio);
          if (energy_out_o !== want.energy)
            report_mismatch("energy_out", energy_out_o, want.energy);
        end
      end
      if (idle_cycles >= WatchdogLimit) begin
        $display("watchdog expired");
        $display("status: fail");
        $finish;
      end
    end
  end

  // random Q16.16 value, half of the time moderate, else extreme or near deadband
  function automatic logic signed [31:0] rand_axis(bit torque);
    int sel;
    logic signed [31:0] v;
    sel = $urandom_range(9);
    case (sel)
      0: v = $urandom;
      1: v = $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      2: v = (torque ? 3277 : 196608) - $urandom_range(2);
      3: v = -((torque ? 3277 : 196608) - $urandom_range(2));
      4: v = 0;
      default: v = $signed($urandom_range(32'h00400000)) - 32'sh00200000;
    endcase
    return v;
  endfunction

  function automatic wrench_t rand_wrench();
    wrench_t w;
    w.fx = rand_axis(0); w.fy = rand_axis(0); w.fz = rand_axis(0);
    w.tx = rand_axis(1); w.ty = rand_axis(1); w.tz = rand_axis(1);
    return w;
  endfunction

  task automatic write_reg(aetc_pkg::cfg_idx_e idx, longint unsigned val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val[aetc_pkg::CfgDataW-1:0];
    reg_val[idx] = idx inside {aetc_pkg::CFG_THRESHOLD, aetc_pkg::CFG_EMAX}
                   ? val & 32'h7fffffff : val & 32'hffffff;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_results();
    while (pending_q.size() > 0 || in_valid_i || twist_q.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic run_phase(int count, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) pending_q.push_back(rand_wrench());
    drain_results();
  endtask

  initial begin
    wrench_t w;
    reg_val[aetc_pkg::CFG_DAMP_LIN] = 1310720;  reg_val[aetc_pkg::CFG_DAMP_ROT] = 655360;
    reg_val[aetc_pkg::CFG_GAIN_LIN] = 11185;    reg_val[aetc_pkg::CFG_GAIN_ROT] = 22370;
    reg_val[aetc_pkg::CFG_DRAIN] = 16384;       reg_val[aetc_pkg::CFG_THRESHOLD] = 655360;
    reg_val[aetc_pkg::CFG_EMAX] = 3276800;      reg_val[aetc_pkg::CFG_SPAN] = 419430;
    for (int i = 0; i < 6; i++) begin
      vel_st[i] = 0;
      held_st[i] = 0;
    end
    tank_e = 0;
    tank_r = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: deadband edges, extremes, saturation at reset defaults
    w = '0; pending_q.push_back(w);
    w = '{196608, -196608, 196607, 3277, -3277, 3276}; pending_q.push_back(w);
    w = '{-196607, 0, 0, -3276, 0, 0}; pending_q.push_back(w);
    w = '{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
          32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff};
    for (int i = 0; i < 6; i++) pending_q.push_back(w);
    w = '{32'sh80000000, 32'sh80000000, 32'sh80000000,
          32'sh80000000, 32'sh80000000, 32'sh80000000};
    for (int i = 0; i < 4; i++) pending_q.push_back(w);
    drain_results();

    // extreme gains drive velocity and damped force into saturation
    write_reg(aetc_pkg::CFG_DAMP_LIN, 0);
    write_reg(aetc_pkg::CFG_DAMP_ROT, 24'hffffff);
    write_reg(aetc_pkg::CFG_GAIN_LIN, 24'hffffff);
    write_reg(aetc_pkg::CFG_GAIN_ROT, 24'hffffff);
    w = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
          32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
    for (int i = 0; i < 6; i++) pending_q.push_back(w);
    drain_results();

    // defaults, no idling
    write_reg(aetc_pkg::CFG_DAMP_LIN, 1310720);
    write_reg(aetc_pkg::CFG_DAMP_ROT, 655360);
    write_reg(aetc_pkg::CFG_GAIN_LIN, 11185);
    write_reg(aetc_pkg::CFG_GAIN_ROT, 22370);
    run_phase(250, 0, 0);

    // ratio saturates: big span, low threshold, no drain
    write_reg(aetc_pkg::CFG_DRAIN, 0);
    write_reg(aetc_pkg::CFG_THRESHOLD, 0);
    write_reg(aetc_pkg::CFG_EMAX, 31'h7fffffff);
    write_reg(aetc_pkg::CFG_SPAN, 24'hffffff);
    run_phase(250, 87, 0);

    // ceiling below threshold keeps ratio at zero, maximum drain
    write_reg(aetc_pkg::CFG_DRAIN, 24'hffffff);
    write_reg(aetc_pkg::CFG_THRESHOLD, 31'h7fffffff);
    write_reg(aetc_pkg::CFG_EMAX, 1000);
    write_reg(aetc_pkg::CFG_SPAN, 0);
    run_phase(250, 0, 87);

    // random register set, both sides idling
    write_reg(aetc_pkg::CFG_DAMP_LIN, $urandom_range(24'hffffff));
    write_reg(aetc_pkg::CFG_DAMP_ROT, $urandom_range(24'hffffff));
    write_reg(aetc_pkg::CFG_GAIN_LIN, $urandom_range(65535));
    write_reg(aetc_pkg::CFG_GAIN_ROT, $urandom_range(65535));
    write_reg(aetc_pkg::CFG_DRAIN, $urandom_range(65535));
    write_reg(aetc_pkg::CFG_THRESHOLD, $urandom_range(1 << 20));
    write_reg(aetc_pkg::CFG_EMAX, $urandom_range(1 << 24) + (1 << 20));
    write_reg(aetc_pkg::CFG_SPAN, $urandom_range(24'hffffff));
    run_phase(300, 24, 24);

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
